>>> rtl/core/dsv_pkg.sv
// ----------------------------------------------------------------------------
// dsv_pkg
// Types and constants shared by the date string validator modules.
// ----------------------------------------------------------------------------
package dsv_pkg;

   localparam int unsigned DM_W   = 7;
   localparam int unsigned YEAR_W = 14;

   // Character codes
   localparam logic [7:0] CH_SLASH = 8'd47;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;

   // Field positions within the string
   localparam logic [1:0] FIELD_DAY   = 2'd0;
   localparam logic [1:0] FIELD_MONTH = 2'd1;
   localparam logic [1:0] FIELD_YEAR  = 2'd2;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_MIN_YEAR = 2'd0;
   localparam logic [1:0] CSR_MAX_YEAR = 2'd1;

   localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1869;
   localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2021;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic              valid_res;
      logic [DM_W-1:0]   day;
      logic [DM_W-1:0]   month;
      logic [YEAR_W-1:0] year;
   } rsp_type;

   // Parse state; y100 and cent track the year mod 100 and (year / 100) mod 4
   typedef struct packed {
      logic [1:0]        field_index;
      logic [2:0]        field_length;
      logic [DM_W-1:0]   day_value;
      logic [DM_W-1:0]   month_value;
      logic [YEAR_W-1:0] year_value;
      logic [6:0]        y100;
      logic [1:0]        cent;
      logic              bad_seen;
   } parse_type;

endpackage

>>> rtl/core/dsv_step.sv
// ----------------------------------------------------------------------------
// dsv_step
// Next parse state and final verdict for one character of the date string.
// ----------------------------------------------------------------------------
module dsv_step import dsv_pkg::*; (
   input  parse_type         cur,
   input  req_type           beat,
   input  logic [YEAR_W-1:0] min_year,
   input  logic [YEAR_W-1:0] max_year,
   output parse_type         nxt,
   output rsp_type           res
);

   logic              is_slash;
   logic              is_digit;
   logic [3:0]        digit;
   logic              in_year;
   logic              full;
   logic [7:0]        dm_acc;
   logic [DM_W-1:0]   dm_src;
   logic [16:0]       year_acc;
   logic [9:0]        t100;
   logic [15:0]       t_scaled;
   logic [3:0]        carry;
   logic [9:0]        carry_x100;
   logic              leap;
   logic [4:0]        lim;
   logic              year_ok;
   logic              len_ok;
   logic              month_ok;
   logic              day_ok;

   assign is_slash = (beat.ch == CH_SLASH);
   assign is_digit = (beat.ch >= CH_ZERO) && (beat.ch <= CH_NINE);
   assign digit    = 4'(beat.ch - CH_ZERO);
   assign in_year  = (cur.field_index >= FIELD_YEAR);
   assign full     = in_year ? (cur.field_length >= 3'd4) : (cur.field_length >= 3'd2);

   assign dm_src   = (cur.field_index == FIELD_DAY) ? cur.day_value : cur.month_value;
   assign dm_acc   = {dm_src, 1'b0} * 8'd5 + {4'd0, digit};
   assign year_acc = {3'd0, cur.year_value} * 17'd10 + {13'd0, digit};

   // Year mod 100 step: t / 100 by reciprocal, exact for t below 1000
   assign t100       = {3'd0, cur.y100} * 10'd10 + {6'd0, digit};
   assign t_scaled   = {6'd0, t100} * 16'd41;
   assign carry      = t_scaled[15:12];
   assign carry_x100 = {6'd0, carry} * 10'd100;

   always_comb begin
      nxt = cur;
      if (is_slash) begin
         if (in_year) begin
            nxt.bad_seen = 1'b1;
         end else begin
            nxt.field_index  = cur.field_index + 2'd1;
            nxt.field_length = 3'd0;
         end
      end else if (is_digit) begin
         if (full) begin
            nxt.bad_seen = 1'b1;
         end else begin
            case (cur.field_index)
               FIELD_DAY: begin
                  nxt.day_value = dm_acc[DM_W-1:0];
               end
               FIELD_MONTH: begin
                  nxt.month_value = dm_acc[DM_W-1:0];
               end
               default: begin
                  nxt.year_value = year_acc[YEAR_W-1:0];
                  nxt.y100       = 7'(t100 - carry_x100);
                  nxt.cent       = {cur.cent[0], 1'b0} + carry[1:0];
               end
            endcase
         end
         if (cur.field_length != 3'd7) begin
            nxt.field_length = cur.field_length + 3'd1;
         end
      end else begin
         nxt.bad_seen = 1'b1;
      end
   end

   // Divisible by 4, and not a century unless the century count is a multiple of 4
   assign leap = (nxt.y100[1:0] == 2'd0) && ((nxt.y100 != 7'd0) || (nxt.cent == 2'd0));

   always_comb begin
      case (nxt.month_value)
         7'd2:                         lim = leap ? 5'd29 : 5'd28;
         7'd4, 7'd6, 7'd9, 7'd11:      lim = 5'd30;
         7'd1, 7'd3, 7'd5, 7'd7,
         7'd8, 7'd10, 7'd12:           lim = 5'd31;
         default:                      lim = 5'd0;
      endcase
   end

   assign year_ok  = (nxt.year_value <= 14'd99) ||
                     ((nxt.year_value >= min_year) && (nxt.year_value <= max_year));
   assign len_ok   = (nxt.field_length >= 3'd2) && (nxt.field_length <= 3'd4);
   assign month_ok = (nxt.month_value >= 7'd1) && (nxt.month_value <= 7'd12);
   assign day_ok   = (nxt.day_value >= 7'd1) && (nxt.day_value <= {2'd0, lim});

   always_comb begin
      res.valid_res = !nxt.bad_seen && (nxt.field_index == FIELD_YEAR) && len_ok &&
                      year_ok && month_ok && day_ok;
      res.day       = nxt.day_value;
      res.month     = nxt.month_value;
      res.year      = nxt.year_value;
   end

endmodule

>>> rtl/core/date_string_validator.sv
// ----------------------------------------------------------------------------
// date_string_validator
// Checks a "dd/mm/yyyy" string fed one character per beat and reports the
// verdict and the parsed fields on the final character.
// ----------------------------------------------------------------------------
//  channel  direction  payload    handshake
//  req_     in         req_type   req_valid / req_stall, one character a beat
//  rsp_     out        rsp_type   rsp_valid / rsp_stall, one beat per string
//  csr_     in         14 bits    csr_we, csr_index, no read-back
//
//  One character a cycle sustained, except while a final character waits behind
//  a stalled result. A character is registered in the input stage when it is
//  accepted and parsed from there, and the result of a final character is
//  registered in the output stage. Reset clears the parse state and loads the
//  year limits 1869 and 2021. While a result is stalled, the next final
//  character waits in the input stage and holds req_stall high; other characters keep flowing.
// ----------------------------------------------------------------------------
module date_string_validator import dsv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [YEAR_W-1:0] csr_wdata
);

   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_beat_ff;
   parse_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;
   logic [YEAR_W-1:0] min_year_ff;
   logic [YEAR_W-1:0] max_year_ff;

   parse_type         step_nxt;
   rsp_type           step_res;
   logic              out_free;
   logic              s1_go;
   logic              req_take;

   dsv_step u_step (
      .cur      (state_ff),
      .beat     (s1_beat_ff),
      .min_year (min_year_ff),
      .max_year (max_year_ff),
      .nxt      (step_nxt),
      .res      (step_res)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_beat_ff.last || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      state_in = state_ff;
      if (s1_go) begin
         // drop the parse state after the final character
         state_in = s1_beat_ff.last ? '0 : step_nxt;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_beat_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         min_year_ff  <= MIN_YEAR_RST;
         max_year_ff  <= MAX_YEAR_RST;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == CSR_MIN_YEAR)) begin
            min_year_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_MAX_YEAR)) begin
            max_year_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_beat_ff <= req_data;
      end
      if (s1_go && s1_beat_ff.last) begin
         rsp_data_ff <= step_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/dsv_checker.sv
// ----------------------------------------------------------------------------
// dsv_checker
// Port-level checks for the date string validator, bound to the top level.
// ----------------------------------------------------------------------------
module dsv_checker import dsv_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat after reset");

   a_valid_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.valid_res |->
         rsp_data.month >= 7'd1 && rsp_data.month <= 7'd12 &&
         rsp_data.day >= 7'd1 && rsp_data.day <= 7'd31)
      else $error("valid date with day or month out of range");

   a_valid_feb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.valid_res && rsp_data.month == 7'd2 |->
         rsp_data.day <= 7'd29)
      else $error("valid February date past day 29");

endmodule

bind date_string_validator dsv_checker u_dsv_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/date_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_checker
// Watches the character, result and register ports of the date string
// validator. It parses every accepted character into its own copy of the
// date fields, queues the expected verdict on each final character, and
// compares each accepted result beat field by field with the oldest entry.
// ----------------------------------------------------------------------------
module date_checker import dsv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [YEAR_W-1:0] csr_wdata,
   output int                mismatches,
   output int                outstanding
);

   logic [YEAR_W-1:0] year_floor;
   logic [YEAR_W-1:0] year_ceiling;

   logic [1:0]        cur_field;
   logic [2:0]        cur_len;
   logic [DM_W-1:0]   day_acc;
   logic [DM_W-1:0]   month_acc;
   logic [YEAR_W-1:0] year_acc;
   logic              fault_seen;

   rsp_type expected_dates[$];
   int      error_count = 0;

   function automatic int days_in_month(input int m, input int y);
      logic leap;
      leap = (y % 4 == 0) && ((y % 400 == 0) || (y % 100 != 0));
      case (m)
         2: return leap ? 29 : 28;
         4, 6, 9, 11: return 30;
         1, 3, 5, 7, 8, 10, 12: return 31;
         default: return 0;
      endcase
   endfunction

   function automatic logic date_is_valid();
      int y = year_acc;
      int m = month_acc;
      int d = day_acc;
      if (fault_seen || cur_field != FIELD_YEAR)
         return 1'b0;
      if (cur_len < 2 || cur_len > 4)
         return 1'b0;
      if (y > 99 && (y < year_floor || y > year_ceiling))
         return 1'b0;
      if (m < 1 || m > 12)
         return 1'b0;
      if (d < 1 || d > days_in_month(m, y))
         return 1'b0;
      return 1'b1;
   endfunction

   task automatic clear_parse();
      cur_field  = FIELD_DAY;
      cur_len    = '0;
      day_acc    = '0;
      month_acc  = '0;
      year_acc   = '0;
      fault_seen = 1'b0;
   endtask

   task automatic parse_char(input req_type beat);
      int      dg;
      int      max_len;
      rsp_type verdict;
      if (beat.ch == CH_SLASH) begin
         // a third slash is a fault; stay in the year
         if (cur_field == FIELD_YEAR)
            fault_seen = 1'b1;
         else begin
            cur_field = cur_field + 2'd1;
            cur_len   = '0;
         end
      end else if (beat.ch >= CH_ZERO && beat.ch <= CH_NINE) begin
         dg      = beat.ch - CH_ZERO;
         max_len = (cur_field == FIELD_YEAR) ? 4 : 2;
         if (cur_len >= max_len)
            fault_seen = 1'b1;
         else if (cur_field == FIELD_DAY)
            day_acc = DM_W'(int'(day_acc) * 10 + dg);
         else if (cur_field == FIELD_MONTH)
            month_acc = DM_W'(int'(month_acc) * 10 + dg);
         else
            year_acc = YEAR_W'(int'(year_acc) * 10 + dg);
         if (cur_len < 3'd7)
            cur_len = cur_len + 3'd1;
      end else begin
         fault_seen = 1'b1;
      end

      if (beat.last) begin
         verdict.valid_res = date_is_valid();
         verdict.day       = day_acc;
         verdict.month     = month_acc;
         verdict.year      = year_acc;
         expected_dates.push_back(verdict);
         clear_parse();
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         year_floor   = MIN_YEAR_RST;
         year_ceiling = MAX_YEAR_RST;
         clear_parse();
         expected_dates.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_YEAR: year_floor = csr_wdata;
               CSR_MAX_YEAR: year_ceiling = csr_wdata;
               default: ;
            endcase
         end

         // compare before queueing: a result never belongs to this edge's beat
         if (rsp_valid && !rsp_stall) begin
            if (expected_dates.size() == 0) begin
               if (error_count < 10)
                  $display("%t unexpected result: valid=%0d day=%0d month=%0d year=%0d",
                           $realtime, rsp_data.valid_res, rsp_data.day,
                           rsp_data.month, rsp_data.year);
               error_count++;
            end else begin
               want = expected_dates.pop_front();
               if (want.valid_res !== rsp_data.valid_res || want.day !== rsp_data.day ||
                   want.month !== rsp_data.month || want.year !== rsp_data.year) begin
                  if (error_count < 10) begin
                     $write("%t date mismatch: expected valid=%0d day=%0d month=%0d year=%0d",
                            $realtime, want.valid_res, want.day, want.month,
                            want.year);
                     $display(", got valid=%0d day=%0d month=%0d year=%0d",
                              rsp_data.valid_res, rsp_data.day,
                              rsp_data.month, rsp_data.year);
                  end
                  error_count++;
               end
            end
         end

         if (req_valid && !req_stall)
            parse_char(req_data);
      end
      mismatches  <= error_count;
      outstanding <= expected_dates.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds date strings to the date string validator one character a beat:
// a few hand-picked strings, then random well-formed dates with occasional
// corruption and some byte noise, across several year-limit settings and
// idle/stall mixes. The checker predicts and compares; this module drives
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module testbench import dsv_pkg::*; ();

   localparam int        LATENCY     = 2;
   localparam int        QUIET_LIMIT = 2000;
   localparam int        PHASE_ITEMS = 136;
   localparam logic [1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [1:0] CSR_SPARE_3 = 2'd3;
   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;
   localparam logic [7:0] CH_TOP      = 8'hFF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = CSR_MIN_YEAR;
   logic [YEAR_W-1:0] csr_wdata = '0;

   int mismatches;
   int outstanding;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int cfg_min = MIN_YEAR_RST;
   int cfg_max = MAX_YEAR_RST;
   int phase_items;

   logic [7:0] line_buf[$];

   always #5 clock = ~clock;

   date_string_validator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   date_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // end the run if neither channel moves a beat for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int num_digits(input int v);
      int n = 1;
      while (v >= 10) begin
         v = v / 10;
         n++;
      end
      return n;
   endfunction

   task automatic send_char(input logic [7:0] c, input logic lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{ch: c, last: lst};
      do
         @(posedge clock);
      while (req_stall);
   endtask

   task automatic send_line();
      foreach (line_buf[i])
         send_char(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_buf.push_back(s[i]);
   endtask

   task automatic add_digits(input int value, input int ndig);
      int div = 1;
      repeat (ndig - 1) div = div * 10;
      for (int i = 0; i < ndig; i++) begin
         line_buf.push_back(CH_ZERO + 8'((value / div) % 10));
         div = div / 10;
      end
   endtask

   task automatic build_date();
      int yr_v;
      int mon_v;
      int day_v;
      int ylen;
      int mlen;
      int dlen;
      int hi;
      int pos;
      case ($urandom_range(9))
         0, 1: yr_v = $urandom_range(99);
         2: yr_v = 100 * int'($urandom_range(24, 16));
         3: yr_v = cfg_min + int'($urandom_range(2)) - 1;
         4: yr_v = cfg_max + int'($urandom_range(2)) - 1;
         5: yr_v = $urandom_range(9999);
         default: begin
            hi = (cfg_max > 9999) ? 9999 : cfg_max;
            if (cfg_min <= hi)
               yr_v = $urandom_range(hi, cfg_min);
            else
               yr_v = $urandom_range(9999);
         end
      endcase
      if (yr_v < 0)
         yr_v = 0;
      if (yr_v > 9999)
         yr_v = 9999;

      mon_v = ($urandom_range(9) != 0) ? $urandom_range(12, 1) : $urandom_range(99);
      case ($urandom_range(3))
         0: day_v = $urandom_range(31, 1);
         1: day_v = $urandom_range(31, 28);
         2: day_v = $urandom_range(9, 1);
         default: day_v = $urandom_range(99);
      endcase

      dlen = num_digits(day_v);
      if (dlen == 1 && $urandom_range(1))
         dlen = 2;
      if ($urandom_range(24) == 0)
         dlen = $urandom_range(1) ? 0 : 3;
      mlen = num_digits(mon_v);
      if (mlen == 1 && $urandom_range(1))
         mlen = 2;
      if ($urandom_range(24) == 0)
         mlen = $urandom_range(1) ? 0 : 3;
      ylen = num_digits(yr_v);
      if (ylen < 2)
         ylen = 2;
      if ($urandom_range(3) == 0)
         ylen = $urandom_range(4, ylen);
      if ($urandom_range(19) == 0)
         ylen = $urandom_range(1) ? 1 : 5;

      add_digits(day_v, dlen);
      line_buf.push_back(CH_SLASH);
      add_digits(mon_v, mlen);
      line_buf.push_back(CH_SLASH);
      add_digits(yr_v, ylen);

      // corrupt a few otherwise well-formed dates
      case ($urandom_range(19))
         0: line_buf.insert($urandom_range(line_buf.size()), 8'($urandom_range(255)));
         1: begin
            pos = -1;
            for (int i = 0; i < line_buf.size(); i++)
               if (pos < 0 && line_buf[i] == CH_SLASH)
                  pos = i;
            if (pos >= 0)
               line_buf.delete(pos);
         end
         2: line_buf.push_back(CH_SLASH);
         3: line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
         default: ;
      endcase
   endtask

   task automatic build_noise();
      repeat ($urandom_range(6, 1)) begin
         case ($urandom_range(3))
            0, 1: line_buf.push_back(8'($urandom_range(255)));
            2: line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
            default: line_buf.push_back(CH_SLASH);
         endcase
      end
   endtask

   // wait for every result, then let the pipeline drain
   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (outstanding != 0);
      repeat (2 * LATENCY) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= YEAR_W'(value);
      @(posedge clock);
   endtask

   task automatic set_limits(input int lo, input int hi);
      write_csr(CSR_MIN_YEAR, lo);
      write_csr(CSR_MAX_YEAR, hi);
      cfg_min = lo;
      cfg_max = hi;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // hand-picked strings at the reset limits
      add_text("29/2/00");
      send_line();
      add_text("///12");
      send_line();
      add_text("123");
      send_line();
      add_text("//99");
      send_line();
      line_buf.push_back(CH_NUL);
      send_line();
      line_buf.push_back(CH_NEWLINE);
      send_line();
      line_buf.push_back(CH_TOP);
      send_line();

      for (int p = 0; p < 8; p++) begin
         drain();
         case (p)
            1: begin
               write_csr(CSR_SPARE_2, $urandom_range(16383));
               set_limits(0, 16383);
            end
            2: set_limits(16383, 0);
            3: set_limits(1600, 2400);
            4: set_limits(2000, 2000);
            5: set_limits(9999, 9999);
            6: begin
               set_limits($urandom_range(16383), $urandom_range(16383));
               write_csr(CSR_SPARE_3, $urandom_range(16383));
               write_csr(CSR_SPARE_2, $urandom_range(16383));
            end
            7: set_limits(MIN_YEAR_RST, MAX_YEAR_RST);
            default: ;
         endcase
         csr_we <= 1'b0;

         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 58; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 58; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
         endcase

         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(99) < 85)
               build_date();
            else
               build_noise();
            phase_items += line_buf.size();
            send_line();
         end
      end

      drain();
      repeat (4 * LATENCY) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
